// File: hdl/rst_pkg.sv
package rst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int RAND_W       = 31;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PICK   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOP   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_PREP,
        S_SHIFT_UP,
        S_PUT,
        S_SHIFT_DN,
        S_DIV,
        S_PICK,
        S_DONE
    } t_state;

endpackage

// File: hdl/rst_mod.sv
module rst_mod #(
    parameter int CNT_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rst_pkg::RAND_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [CNT_W-1:0]          o_remainder
);

    localparam int STEP_W = $clog2(rst_pkg::RAND_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [rst_pkg::RAND_W-1:0] r_dvd;
    logic [CNT_W-1:0]           r_rem;
    logic [CNT_W:0]             trial;
    logic [CNT_W-1:0]           n_rem;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial = {r_rem, r_dvd[rst_pkg::RAND_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = CNT_W'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = CNT_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(rst_pkg::RAND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rst_pkg::RAND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// File: hdl/randomized_set_table_unit.sv
// sorted set of distinct signed 32-bit values, one request at a time
// insert/remove: run time depends on N (N = entries held), set by the
//   linear search and the one-entry-per-cycle shift through the store
// pick: the bit-serial remainder unit, then a store read; empty pick and unused kind go straight to the strobe
// busy drops with the strobe, and a new request can be accepted in that same cycle; strobe cannot be held off
// synchronous active-low reset empties the set; store contents are not cleared
module randomized_set_table_unit #(
    parameter int CAPACITY = rst_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rst_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [rst_pkg::DATA_W-1:0] i_value,
    input  logic [rst_pkg::RAND_W-1:0]    i_random_word,
    output logic                          o_strobe,
    output logic [rst_pkg::STATUS_W-1:0]  o_status,
    output logic signed [rst_pkg::DATA_W-1:0] o_picked_value,
    output logic [rst_pkg::COUNT_OUT_W-1:0] o_entry_count
);

    // count needs to hold CAPACITY itself, addresses only CAPACITY-1
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // sequencer state
    rst_pkg::t_state r_state, n_state;

    // request and working registers
    logic [rst_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [rst_pkg::DATA_W-1:0]   r_value, n_value;
    logic [CW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_pos, n_pos;
    logic [CW-1:0]                r_count, n_count;
    logic [rst_pkg::STATUS_W-1:0] r_status, n_status;
    logic [rst_pkg::DATA_W-1:0]   r_picked, n_picked;

    // result registers
    logic                          r_strobe, n_strobe;
    logic [rst_pkg::STATUS_W-1:0]  r_o_status;
    logic [rst_pkg::DATA_W-1:0]    r_o_picked;
    logic [CW-1:0]                 r_o_count;

    // store: one write port, one registered read port
    logic [rst_pkg::DATA_W-1:0] mem [CAPACITY];
    logic [rst_pkg::DATA_W-1:0] r_rdata;
    logic [CW-1:0]              rd_addr;
    logic                       rd_ok;
    logic                       mem_we;
    logic [CW-1:0]              mem_wa;
    logic [rst_pkg::DATA_W-1:0] mem_wd;

    // remainder unit
    logic          div_start;
    logic          div_done;
    logic [CW-1:0] div_rem;

    logic accept;
    logic at_end;
    logic is_eq;
    logic is_gt;
    logic [CW:0] idx_plus1;
    logic [CW:0] idx_plus2;

    assign accept = start && !busy;
    assign busy   = (r_state != rst_pkg::S_IDLE);

    // entry compare during the search walk
    assign at_end    = (r_idx >= r_count);
    assign is_eq     = (r_rdata == r_value);
    assign is_gt     = ($signed(r_rdata) > $signed(r_value));
    assign idx_plus1 = {1'b0, r_idx} + 1'b1;
    assign idx_plus2 = {1'b0, r_idx} + 2'd2;

    // the divider loads its dividend at the accept edge, straight from the request
    rst_mod #(
        .CNT_W (CW)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_random_word),
        .i_divisor   (r_count),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rst_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_kind == rst_pkg::KIND_INSERT || i_kind == rst_pkg::KIND_REMOVE) begin
                        n_state = rst_pkg::S_SEARCH;
                    end else if (i_kind == rst_pkg::KIND_PICK && r_count != '0) begin
                        n_state = rst_pkg::S_DIV;
                    end else begin
                        n_state = rst_pkg::S_DONE;
                    end
                end
            end
            rst_pkg::S_SEARCH: begin
                if (at_end || is_gt) begin
                    // value absent
                    if (r_kind == rst_pkg::KIND_INSERT && r_count < CW'(CAPACITY)) begin
                        n_state = rst_pkg::S_PREP;
                    end else begin
                        n_state = rst_pkg::S_DONE;
                    end
                end else if (is_eq) begin
                    if (r_kind == rst_pkg::KIND_REMOVE && idx_plus1 < {1'b0, r_count}) begin
                        n_state = rst_pkg::S_SHIFT_DN;
                    end else begin
                        n_state = rst_pkg::S_DONE;
                    end
                end
            end
            rst_pkg::S_PREP: begin
                if (r_count > r_pos) begin
                    n_state = rst_pkg::S_SHIFT_UP;
                end else begin
                    n_state = rst_pkg::S_PUT;
                end
            end
            rst_pkg::S_SHIFT_UP: begin
                if (r_idx - 1'b1 == r_pos) begin
                    n_state = rst_pkg::S_PUT;
                end
            end
            rst_pkg::S_PUT: n_state = rst_pkg::S_DONE;
            rst_pkg::S_SHIFT_DN: begin
                if (idx_plus2 >= {1'b0, r_count}) begin
                    n_state = rst_pkg::S_DONE;
                end
            end
            rst_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = rst_pkg::S_PICK;
                end
            end
            rst_pkg::S_PICK: n_state = rst_pkg::S_DONE;
            rst_pkg::S_DONE: n_state = rst_pkg::S_IDLE;
            default:         n_state = rst_pkg::S_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb begin
        n_kind    = r_kind;
        n_value   = r_value;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_count   = r_count;
        n_status  = r_status;
        n_picked  = r_picked;
        n_strobe  = 1'b0;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_wa    = r_idx;
        mem_wd    = r_rdata;
        div_start = 1'b0;
        unique case (r_state)
            rst_pkg::S_IDLE: begin
                // entry 0 is always on the read port so the search starts at once
                rd_addr = '0;
                if (accept) begin
                    n_kind   = i_kind;
                    n_value  = i_value;
                    n_idx    = '0;
                    n_status = rst_pkg::STATUS_OK;
                    n_picked = '0;
                    if (i_kind == rst_pkg::KIND_PICK) begin
                        if (r_count == '0) begin
                            n_status = rst_pkg::STATUS_EMPTY;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                end
            end
            rst_pkg::S_SEARCH: begin
                // prefetch the next entry while comparing this one
                rd_addr = CW'(idx_plus1);
                n_pos   = r_idx;
                if (at_end || is_gt) begin
                    if (r_kind == rst_pkg::KIND_REMOVE) begin
                        n_status = rst_pkg::STATUS_NOP;
                    end else if (r_count >= CW'(CAPACITY)) begin
                        n_status = rst_pkg::STATUS_FULL;
                    end
                end else if (is_eq) begin
                    if (r_kind == rst_pkg::KIND_INSERT) begin
                        n_status = rst_pkg::STATUS_NOP;
                    end else if (idx_plus1 >= {1'b0, r_count}) begin
                        // last entry removed, nothing to close up
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    n_idx = CW'(idx_plus1);
                end
            end
            rst_pkg::S_PREP: begin
                // fetch the top entry, first to move up
                rd_addr = r_count - 1'b1;
                n_idx   = r_count;
            end
            rst_pkg::S_SHIFT_UP: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_rdata;
                rd_addr = r_idx - 2'd2;
                n_idx   = r_idx - 1'b1;
            end
            rst_pkg::S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos;
                mem_wd  = r_value;
                n_count = r_count + 1'b1;
            end
            rst_pkg::S_SHIFT_DN: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_rdata;
                rd_addr = CW'(idx_plus2);
                n_idx   = CW'(idx_plus1);
                if (idx_plus2 >= {1'b0, r_count}) begin
                    n_count = r_count - 1'b1;
                end
            end
            rst_pkg::S_DIV: begin
                // remainder is the rank, read it as soon as it is ready
                rd_addr = div_rem;
            end
            rst_pkg::S_PICK: begin
                n_picked = r_rdata;
            end
            rst_pkg::S_DONE: begin
                n_strobe = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // reads beyond the store are dropped, their data is never used
    assign rd_ok = (rd_addr < CW'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        if (rd_ok) begin
            r_rdata <= mem[rd_addr[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rst_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_picked <= n_picked;
        if (n_strobe) begin
            r_o_status <= r_status;
            r_o_picked <= r_picked;
            r_o_count  <= r_count;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_o_status;
    assign o_picked_value = r_o_picked;
    assign o_entry_count  = rst_pkg::COUNT_OUT_W'(r_o_count);

    // a request keeps the block busy until its result is out
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

    // count never exceeds the store size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // full is reported only with the store at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == rst_pkg::STATUS_FULL)
            |-> (r_o_count == CW'(CAPACITY)))
        else $error("full status with store not full");

    // empty pick gives zero value and zero count
    a_empty_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == rst_pkg::STATUS_EMPTY)
            |-> (o_picked_value == '0 && r_o_count == '0))
        else $error("empty status with nonzero value or count");

    // a result appears only when the sequencer has just finished
    a_strobe_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == rst_pkg::S_DONE))
        else $error("result strobe without finished request");

endmodule

// File: bench/tb_randomized_set_table_unit.sv
`timescale 1ns / 100ps

module tb_randomized_set_table_unit;

    localparam int CAP         = rst_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT = 2000;   // longest sender gap plus longest op, with margin
    localparam int DRAIN_WAIT  = 60;     // a little beyond the slowest operation
    localparam int POOL_SIZE   = 24;     // a bit above capacity so hits and misses both occur
    localparam int RANDOM_REQS = 1800;

    // one request as driven onto the ports
    typedef struct {
        logic [rst_pkg::KIND_W-1:0]        kind;
        logic signed [rst_pkg::DATA_W-1:0] value;
        logic [rst_pkg::RAND_W-1:0]        rword;
    } t_set_request;

    // one result as the block should report it
    typedef struct {
        logic [rst_pkg::STATUS_W-1:0]       status;
        logic signed [rst_pkg::DATA_W-1:0]  picked;
        logic [rst_pkg::COUNT_OUT_W-1:0]    count;
    } t_set_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [rst_pkg::KIND_W-1:0]          i_kind = rst_pkg::KIND_INSERT;
    logic signed [rst_pkg::DATA_W-1:0]   i_value = '0;
    logic [rst_pkg::RAND_W-1:0]          i_random_word = '0;
    logic                                o_strobe;
    logic [rst_pkg::STATUS_W-1:0]        o_status;
    logic signed [rst_pkg::DATA_W-1:0]   o_picked_value;
    logic [rst_pkg::COUNT_OUT_W-1:0]     o_entry_count;

    // requests waiting to be driven, and results still owed by the block
    t_set_request pending_req_q[$];
    t_set_result  owed_result_q[$];
    t_set_request cur_req;

    // shadow copy of the set, ascending signed order
    logic signed [rst_pkg::DATA_W-1:0] shadow_vals [CAP];
    int                                shadow_count = 0;

    int error_count  = 0;
    int stall_cycles = 0;
    int burst_left   = 1;
    int gap_left     = 0;

    randomized_set_table_unit #(
        .CAPACITY(CAP)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_value(i_value),
        .i_random_word(i_random_word),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_picked_value(o_picked_value),
        .o_entry_count(o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the shadow set and return what the block should report
    function automatic t_set_result apply_set_request(input t_set_request req);
        t_set_result res;
        int          slot;
        int          i;
        bit          hit;
        res.status = rst_pkg::STATUS_OK;
        res.picked = '0;
        // first slot whose entry is not below the value
        slot = 0;
        while (slot < shadow_count && shadow_vals[slot] < req.value)
            slot++;
        hit = (slot < shadow_count) && (shadow_vals[slot] == req.value);
        case (req.kind)
            rst_pkg::KIND_INSERT: begin
                if (hit) begin
                    res.status = rst_pkg::STATUS_NOP;
                end else if (shadow_count >= CAP) begin
                    res.status = rst_pkg::STATUS_FULL;
                end else begin
                    for (i = shadow_count; i > slot; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[slot] = req.value;
                    shadow_count++;
                end
            end
            rst_pkg::KIND_REMOVE: begin
                if (!hit) begin
                    res.status = rst_pkg::STATUS_NOP;
                end else begin
                    for (i = slot; i + 1 < shadow_count; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_count--;
                end
            end
            rst_pkg::KIND_PICK: begin
                if (shadow_count == 0)
                    res.status = rst_pkg::STATUS_EMPTY;
                else
                    res.picked = shadow_vals[int'(req.rword) % shadow_count];
            end
            default: ;
        endcase
        res.count = shadow_count[rst_pkg::COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic queue_request(input logic [rst_pkg::KIND_W-1:0] kind,
                                 input logic signed [rst_pkg::DATA_W-1:0] value,
                                 input logic [rst_pkg::RAND_W-1:0] rword);
        t_set_request req;
        req.kind  = kind;
        req.value = value;
        req.rword = rword;
        pending_req_q.push_back(req);
    endtask

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch on %s: expected %h, got %h at %0t", fname, want, got, $time);
        end
    endtask

    // driver: raise start per request, hold it until accepted, bursts and gaps between
    always @(posedge i_clk) begin : driver
        t_set_request nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // accepted at this edge: predict from what was on the ports
            if (start && !busy)
                owed_result_q.push_back(apply_set_request(cur_req));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_req_q.size() > 0) begin
                    nxt = pending_req_q.pop_front();
                    cur_req = nxt;
                    i_kind <= nxt.kind;
                    i_value <= nxt.value;
                    i_random_word <= nxt.rword;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // new burst; one in four runs back to back with no gap
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe carries one result, compared with the oldest owed one
    always @(posedge i_clk) begin : monitor
        t_set_result want;
        if (i_rst_n && o_strobe) begin
            if (owed_result_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result with nothing owed: status %0d at %0t", o_status, $time);
            end else begin
                want = owed_result_q.pop_front();
                check_field("status", 32'(o_status), 32'(want.status));
                check_field("picked_value", o_picked_value, want.picked);
                check_field("entry_count", 32'(o_entry_count), 32'(want.count));
            end
        end
    end

    // watchdog: nothing accepted on either side for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic signed [rst_pkg::DATA_W-1:0] pool [POOL_SIZE];
        logic [31:0]                       raw;
        logic [rst_pkg::KIND_W-1:0]        kind;
        logic signed [rst_pkg::DATA_W-1:0] value;
        int                                k;
        int                                seg_left;
        int                                insert_cut;
        int                                roll;

        // directed: empty-store cases first
        queue_request(rst_pkg::KIND_PICK, 32'sd5, 31'd7);             // pick from empty store
        queue_request(rst_pkg::KIND_REMOVE, 32'sd0, '0);              // remove from empty store
        // both extremes and the values around zero
        queue_request(rst_pkg::KIND_INSERT, 32'sh7FFF_FFFF, '0);
        queue_request(rst_pkg::KIND_INSERT, 32'sh8000_0000, '0);
        queue_request(rst_pkg::KIND_INSERT, 32'sd0, '0);
        queue_request(rst_pkg::KIND_INSERT, -32'sd1, '0);
        queue_request(rst_pkg::KIND_INSERT, 32'sd1, '0);
        queue_request(rst_pkg::KIND_INSERT, 32'sd0, '0);              // already present
        queue_request(rst_pkg::KIND_PICK, '0, '0);                    // smallest entry
        queue_request(rst_pkg::KIND_PICK, '0, 31'h7FFF_FFFF);         // largest random word
        queue_request(rst_pkg::KIND_REMOVE, 32'sd0, '0);
        queue_request(rst_pkg::KIND_REMOVE, 32'sd0, '0);              // now absent
        // fill to capacity, then a new value and a held value into the full store
        for (k = 0; k < CAP - 4; k++)
            queue_request(rst_pkg::KIND_INSERT, 32'(k * 1000 - 6000), '0);
        queue_request(rst_pkg::KIND_INSERT, 32'sd123456, '0);         // store full
        queue_request(rst_pkg::KIND_INSERT, 32'sh7FFF_FFFF, '0);      // held value while full
        queue_request(rst_pkg::KIND_PICK, '0, 31'd15);                // last rank
        queue_request(rst_pkg::KIND_REMOVE, 32'sh8000_0000, '0);
        queue_request(rst_pkg::KIND_REMOVE, 32'sh7FFF_FFFF, '0);

        // value pool: extremes plus random values, so inserts and removes both hit
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7FFF_FFFF;
        pool[2] = 32'sd0;
        pool[3] = -32'sd1;
        pool[4] = 32'sd1;
        for (k = 5; k < POOL_SIZE; k++)
            pool[k] = $urandom;

        // random: segments that lean toward filling, draining, or neither
        seg_left = 0;
        insert_cut = 57;
        for (k = 0; k < RANDOM_REQS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 90);
                case ($urandom_range(0, 2))
                    0:       insert_cut = 75;   // fill toward full
                    1:       insert_cut = 35;   // drain toward empty
                    default: insert_cut = 57;
                endcase
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < 15)
                kind = rst_pkg::KIND_PICK;
            else if (roll < insert_cut)
                kind = rst_pkg::KIND_INSERT;
            else
                kind = rst_pkg::KIND_REMOVE;
            // mostly pooled values, sometimes a fresh full-range one
            if ($urandom_range(0, 9) < 8)
                value = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                value = $urandom;
            raw = $urandom;
            if ($urandom_range(0, 3) == 0)
                raw = $urandom_range(0, 40);
            queue_request(kind, value, raw[rst_pkg::RAND_W-1:0]);
        end

        // reset once, synchronous, then released
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every request is accepted and every result has come back
        @(posedge i_clk);
        while (pending_req_q.size() != 0 || start || owed_result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0 && owed_result_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
